@@ sv/xmsd_pkg.sv @@
// Package for the ModRM/SIB operand decoder.
// Holds the decoder phase type and the ModRM/SIB field codes; no dependencies.
package xmsd_pkg;

    // Decoder phase; the fourth code is unused and decodes like the ModRM phase.
    typedef enum logic [1:0] {
        PH_MODRM = 2'd0,
        PH_SIB   = 2'd1,
        PH_DISP  = 2'd2
    } phase_t;

    localparam logic [1:0] MOD_NO_DISP = 2'b00;
    localparam logic [1:0] MOD_DISP8   = 2'b01;
    localparam logic [1:0] MOD_DISP32  = 2'b10;
    localparam logic [1:0] MOD_REG     = 2'b11;

    localparam logic [2:0] RM_SIB      = 3'b100;
    localparam logic [2:0] RM_DISP32   = 3'b101;
    localparam logic [2:0] INDEX_NONE  = 3'b100;

    localparam logic [2:0] DISP_NONE   = 3'd0;
    localparam logic [2:0] DISP_BYTE   = 3'd1;
    localparam logic [2:0] DISP_DWORD  = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_SIB = 1'b1;

endpackage

@@ sv/x86_modrm_sib_operand_decoder.sv @@
// The result is registered and appears in the cycle after the byte that completes the operand.
// Throughput: one byte accepted every cycle while in_ready is high; 1 to 6 bytes per operand record.
// The single output register decouples the sides: in_ready stays high while it is
// empty or being taken in the same cycle.
// Reset (rst_n, asynchronous, active low) returns the decoder to expect a ModRM
// byte and empties the output register.
// Top level of the ModRM/SIB operand decoder; uses xmsd_pkg.
module x86_modrm_sib_operand_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         code_byte,
    input  logic [3:0]         reg_operand_size,
    input  logic [3:0]         rm_operand_size,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         reg_number,
    output logic [3:0]         reg_size_out,
    output logic               rm_is_memory,
    output logic               base_present,
    output logic [2:0]         base_number,
    output logic               index_present,
    output logic [2:0]         index_number,
    output logic [1:0]         scale_code,
    output logic signed [31:0] displacement,
    output logic [3:0]         rm_size_out,
    output logic               status
);

    xmsd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [7:0]  sib_reg, sib_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic [2:0]  total_reg, total_next;
    logic [3:0]  reg_sz_reg, reg_sz_next;
    logic [3:0]  rm_sz_reg, rm_sz_next;

    logic        emit;
    logic        emit_status;
    logic [2:0]  nbytes;
    logic [1:0]  pos;
    logic        in_fire;

    // Output record fields, built from the updated latches.
    logic [1:0]  e_mod;
    logic [2:0]  e_rm;
    logic        e_mem;
    logic        e_bp;
    logic [2:0]  e_bn;
    logic        e_ip;
    logic [2:0]  e_inum;
    logic [1:0]  e_sc;
    logic [31:0] e_disp;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  reg_number_reg;
    logic [3:0]  reg_size_reg;
    logic        mem_reg;
    logic        bp_reg;
    logic [2:0]  bn_reg;
    logic        ip_reg;
    logic [2:0]  inum_reg;
    logic [1:0]  sc_reg;
    logic [31:0] disp_reg;
    logic [3:0]  rm_size_reg;
    logic        status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        modrm_next  = modrm_reg;
        sib_next    = sib_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        reg_sz_next = reg_sz_reg;
        rm_sz_next  = rm_sz_reg;
        emit        = 1'b0;
        emit_status = xmsd_pkg::STATUS_OK;
        nbytes      = xmsd_pkg::DISP_NONE;
        pos         = total_reg[1:0] - left_reg[1:0];

        unique case (phase_reg)
            xmsd_pkg::PH_SIB:
            begin
                sib_next = code_byte;
                if (code_byte[5:3] == xmsd_pkg::INDEX_NONE)
                begin
                    phase_next  = xmsd_pkg::PH_MODRM;
                    acc_next    = '0;
                    total_next  = xmsd_pkg::DISP_NONE;
                    left_next   = xmsd_pkg::DISP_NONE;
                    emit        = 1'b1;
                    emit_status = xmsd_pkg::STATUS_BAD_SIB;
                end
                else
                begin
                    if (modrm_reg[7:6] == xmsd_pkg::MOD_DISP8)
                        nbytes = xmsd_pkg::DISP_BYTE;
                    else if (modrm_reg[7:6] == xmsd_pkg::MOD_DISP32)
                        nbytes = xmsd_pkg::DISP_DWORD;
                    else if (code_byte[2:0] == xmsd_pkg::RM_DISP32)
                        nbytes = xmsd_pkg::DISP_DWORD;
                    acc_next   = '0;
                    total_next = nbytes;
                    left_next  = nbytes;
                    if (nbytes == xmsd_pkg::DISP_NONE)
                    begin
                        phase_next = xmsd_pkg::PH_MODRM;
                        emit       = 1'b1;
                    end
                    else
                        phase_next = xmsd_pkg::PH_DISP;
                end
            end
            xmsd_pkg::PH_DISP:
            begin
                unique case (pos)
                    2'd0: acc_next[7:0]   = acc_reg[7:0]   | code_byte;
                    2'd1: acc_next[15:8]  = acc_reg[15:8]  | code_byte;
                    2'd2: acc_next[23:16] = acc_reg[23:16] | code_byte;
                    default: acc_next[31:24] = acc_reg[31:24] | code_byte;
                endcase
                left_next = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    phase_next = xmsd_pkg::PH_MODRM;
                    emit       = 1'b1;
                end
            end
            default:
            begin
                // ModRM byte; the unused phase code lands here as well.
                modrm_next  = code_byte;
                sib_next    = '0;
                reg_sz_next = reg_operand_size;
                rm_sz_next  = rm_operand_size;
                acc_next    = '0;
                total_next  = xmsd_pkg::DISP_NONE;
                left_next   = xmsd_pkg::DISP_NONE;
                phase_next  = xmsd_pkg::PH_MODRM;
                if (code_byte[7:6] == xmsd_pkg::MOD_REG)
                    emit = 1'b1;
                else if (code_byte[2:0] == xmsd_pkg::RM_SIB)
                    phase_next = xmsd_pkg::PH_SIB;
                else
                begin
                    if (code_byte[7:6] == xmsd_pkg::MOD_NO_DISP &&
                        code_byte[2:0] == xmsd_pkg::RM_DISP32)
                        nbytes = xmsd_pkg::DISP_DWORD;
                    else if (code_byte[7:6] == xmsd_pkg::MOD_DISP8)
                        nbytes = xmsd_pkg::DISP_BYTE;
                    else if (code_byte[7:6] == xmsd_pkg::MOD_DISP32)
                        nbytes = xmsd_pkg::DISP_DWORD;
                    total_next = nbytes;
                    left_next  = nbytes;
                    if (nbytes == xmsd_pkg::DISP_NONE)
                        emit = 1'b1;
                    else
                        phase_next = xmsd_pkg::PH_DISP;
                end
            end
        endcase
    end

    // Record assembly from the latches as they stand after this byte.
    always_comb
    begin
        e_mod  = modrm_next[7:6];
        e_rm   = modrm_next[2:0];
        e_mem  = 1'b0;
        e_bp   = 1'b0;
        e_bn   = e_rm;
        e_ip   = 1'b0;
        e_inum = '0;
        e_sc   = '0;
        e_disp = '0;
        if (e_mod == xmsd_pkg::MOD_REG)
            e_bp = 1'b1;
        else
        begin
            e_mem = 1'b1;
            if (e_rm == xmsd_pkg::RM_SIB)
            begin
                e_inum = sib_next[5:3];
                e_sc   = sib_next[7:6];
                e_bn   = sib_next[2:0];
                if (emit_status == xmsd_pkg::STATUS_OK)
                begin
                    e_ip = 1'b1;
                    e_bp = !(e_mod == xmsd_pkg::MOD_NO_DISP &&
                             sib_next[2:0] == xmsd_pkg::RM_DISP32);
                end
            end
            else
                e_bp = !(e_mod == xmsd_pkg::MOD_NO_DISP && e_rm == xmsd_pkg::RM_DISP32);
            if (emit_status == xmsd_pkg::STATUS_OK)
            begin
                if (total_next == xmsd_pkg::DISP_BYTE)
                    e_disp = {{24{acc_next[7]}}, acc_next[7:0]};
                else if (total_next == xmsd_pkg::DISP_DWORD)
                    e_disp = acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= xmsd_pkg::PH_MODRM;
            modrm_reg  <= '0;
            sib_reg    <= '0;
            acc_reg    <= '0;
            left_reg   <= '0;
            total_reg  <= '0;
            reg_sz_reg <= '0;
            rm_sz_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            modrm_reg  <= modrm_next;
            sib_reg    <= sib_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            reg_sz_reg <= reg_sz_next;
            rm_sz_reg  <= rm_sz_next;
        end
    end

    always_comb
    begin
        if (in_fire && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            reg_number_reg <= modrm_next[5:3];
            reg_size_reg   <= reg_sz_next;
            mem_reg        <= e_mem;
            bp_reg         <= e_bp;
            bn_reg         <= e_bn;
            ip_reg         <= e_ip;
            inum_reg       <= e_inum;
            sc_reg         <= e_sc;
            disp_reg       <= e_disp;
            rm_size_reg    <= rm_sz_next;
            status_reg     <= emit_status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reg_number    = reg_number_reg;
    assign reg_size_out  = reg_size_reg;
    assign rm_is_memory  = mem_reg;
    assign base_present  = bp_reg;
    assign base_number   = bn_reg;
    assign index_present = ip_reg;
    assign index_number  = inum_reg;
    assign scale_code    = sc_reg;
    assign displacement  = disp_reg;
    assign rm_size_out   = rm_size_reg;
    assign status        = status_reg;

endmodule

@@ sv/xmsd_checker.sv @@
// Port-level checks for the ModRM/SIB operand decoder, bound to its top level.
// Sees only the top-level ports; uses no package.
module xmsd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               rm_is_memory,
    input logic               base_present,
    input logic               index_present,
    input logic signed [31:0] displacement,
    input logic               status
);

    // A record that waits must keep its displacement and status.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(displacement) && $stable(status))
        else $error("output item changed while stalled");

    // The input side is open whenever the output register is free or being drained.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output register");

    // A register operand carries a base and nothing else.
    a_reg_operand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rm_is_memory |-> base_present && !index_present &&
                                       displacement == 0 && status == 1'b0)
        else $error("register operand with memory fields");

    // A bad SIB byte gives a memory record with no base, index or displacement.
    a_bad_sib: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> rm_is_memory && !base_present && !index_present &&
                                displacement == 0)
        else $error("bad SIB record carries operand fields");

endmodule

bind x86_modrm_sib_operand_decoder xmsd_checker u_xmsd_checker (.*);
